FILE: rtl/recency_ordered_list_core_assert.svh
// assertion macros for the recency ordered list core
// depends on nothing; included by modules that carry assertions
`ifndef RECENCY_ORDERED_LIST_CORE_ASSERT_SVH
`define RECENCY_ORDERED_LIST_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define ROL_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ROL_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);
`else
`define ROL_ASSERT(label, clk, rst_n, prop, msg)
`define ROL_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

FILE: rtl/rol_pkg.sv
// shared constants for the recency ordered list core
// no dependencies
`default_nettype none
package rol_pkg;
    localparam int unsigned LIST_DEPTH_DEF = 16;
    localparam int unsigned KEY_W = 32;
    localparam logic [1:0] MODE_APPEND = 2'd0;
    localparam logic [1:0] MODE_POP    = 2'd1;
    localparam logic [1:0] MODE_MOVE   = 2'd2;
    localparam logic [1:0] MODE_REMOVE = 2'd3;
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_MISSING = 2'd3;
endpackage
`default_nettype wire

FILE: rtl/rol_ram.sv
// generic single-port-write, single-read ram with registered read
// no dependencies
`default_nettype none
module rol_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

FILE: rtl/recency_ordered_list_core.sv
// recency ordered list: bounded list of 32-bit values with append, pop front,
// move match to tail and remove match; values live in one ram, one entry a cycle
// append and empty pop go from idle straight to done, where the result is registered;
// pop/move/remove scan the filled entries, then shift and done; a held result stalls in done
// reset: rst_n async active low empties the list; ram contents need no clearing
`default_nettype none
`include "recency_ordered_list_core_assert.svh"
module recency_ordered_list_core #(
    parameter int unsigned LIST_DEPTH = rol_pkg::LIST_DEPTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // mode[1:0], key_value[33:2], zero pad
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata    // front_value[31:0], status[33:32], entry_count[38:34]
);
    localparam int unsigned AW = $clog2(LIST_DEPTH);
    localparam int unsigned CW = $clog2(LIST_DEPTH + 1);

    typedef enum logic [2:0] {IDLE, SCAN, SHIFT, DONE} state_t;

    state_t         state_reg;
    logic [CW-1:0]  count_reg;
    logic [1:0]     mode_reg;
    logic [31:0]    key_reg;
    logic [CW-1:0]  idx_reg;      // address being read
    logic           rdv_reg;      // read data valid for idx_reg-1
    logic           found_reg;
    logic [31:0]    front_reg;
    logic [1:0]     status_reg;
    logic           out_valid_reg;
    logic [39:0]    out_data_reg;

    logic           we;
    logic [AW-1:0]  waddr, raddr;
    logic [31:0]    wdata, rdata;
    logic [CW-1:0]  prev_idx;
    logic           out_stall;

    rol_ram #(.WIDTH(32), .DEPTH(LIST_DEPTH)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    // accept a new transaction whenever idle; a waiting result is held in the output register
    assign s_tready  = (state_reg == IDLE);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign raddr     = idx_reg[AW-1:0];
    assign prev_idx  = idx_reg - CW'(1);
    assign out_stall = m_tvalid && !m_tready;

    // scan: read entries in order; before a match nothing is written, after it
    // each entry read at i is written to i-1, closing the gap
    always_comb
    begin
        we    = 1'b0;
        waddr = '0;
        wdata = rdata;
        if (state_reg == IDLE && s_tvalid && s_tready && s_tdata[1:0] == rol_pkg::MODE_APPEND
            && count_reg < CW'(LIST_DEPTH))
        begin
            we    = 1'b1;
            waddr = count_reg[AW-1:0];
            wdata = s_tdata[33:2];
        end
        else if (state_reg == SCAN && rdv_reg && found_reg)
        begin
            we    = 1'b1;
            waddr = AW'(prev_idx - CW'(1));
        end
        // move puts the key at the tail only after a match
        else if (state_reg == SHIFT && mode_reg == rol_pkg::MODE_MOVE && found_reg)
        begin
            we    = 1'b1;
            waddr = AW'(count_reg - CW'(1));
            wdata = key_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            rdv_reg       <= 1'b0;
            found_reg     <= 1'b0;
            mode_reg      <= rol_pkg::MODE_APPEND;
            key_reg       <= '0;
            front_reg     <= '0;
            status_reg    <= rol_pkg::ST_OK;
            out_data_reg  <= '0;
        end
        else
        begin
            if (out_valid_reg && m_tready && state_reg != DONE)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                IDLE:
                begin
                    if (s_tvalid && s_tready)
                    begin
                        mode_reg   <= s_tdata[1:0];
                        key_reg    <= s_tdata[33:2];
                        front_reg  <= '0;
                        status_reg <= rol_pkg::ST_OK;
                        idx_reg    <= '0;
                        rdv_reg    <= 1'b0;
                        found_reg  <= 1'b0;
                        if (s_tdata[1:0] == rol_pkg::MODE_APPEND)
                        begin
                            if (count_reg < CW'(LIST_DEPTH))
                            begin
                                count_reg <= count_reg + CW'(1);
                            end
                            else
                            begin
                                status_reg <= rol_pkg::ST_FULL;
                            end
                            state_reg <= DONE;
                        end
                        else if (s_tdata[1:0] == rol_pkg::MODE_POP && count_reg == '0)
                        begin
                            status_reg <= rol_pkg::ST_EMPTY;
                            state_reg  <= DONE;
                        end
                        else
                        begin
                            state_reg <= SCAN;
                        end
                    end
                end
                SCAN:
                begin
                    // rdata holds entry prev_idx when rdv_reg
                    if (rdv_reg && !found_reg)
                    begin
                        if (mode_reg == rol_pkg::MODE_POP)
                        begin
                            front_reg <= rdata;
                            found_reg <= 1'b1;
                        end
                        else if (rdata == key_reg)
                        begin
                            found_reg <= 1'b1;
                        end
                    end
                    if (idx_reg < count_reg)
                    begin
                        idx_reg <= idx_reg + CW'(1);
                        rdv_reg <= 1'b1;
                    end
                    else
                    begin
                        rdv_reg <= 1'b0;
                        if (rdv_reg || count_reg == '0)
                        begin
                            state_reg <= SHIFT;
                        end
                    end
                end
                SHIFT:
                begin
                    if (!found_reg)
                    begin
                        status_reg <= rol_pkg::ST_MISSING;
                    end
                    else if (mode_reg != rol_pkg::MODE_MOVE)
                    begin
                        count_reg <= count_reg - CW'(1);
                    end
                    state_reg <= DONE;
                end
                DONE:
                begin
                    // load the result once the previous one has gone or goes now
                    if (!out_valid_reg || m_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= {1'b0, 5'(count_reg), status_reg, front_reg};
                        state_reg     <= IDLE;
                    end
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    `ROL_ASSERT(a_count_range, clk, rst_n, (count_reg <= CW'(LIST_DEPTH)), "fill count overflow")
    `ROL_ASSERT_NEXT(a_start, clk, rst_n, (s_tvalid && s_tready), (state_reg != IDLE), "no start")
    `ROL_ASSERT_NEXT(a_hold, clk, rst_n, out_stall, (m_tvalid && $stable(m_tdata)), "hold lost")
endmodule
`default_nettype wire

FILE: tb/testbench.sv
// self-checking testbench for recency_ordered_list_core: directed table then random traffic
// depends on rol_pkg and the recency_ordered_list_core rtl
`timescale 1ns / 1ps
`default_nettype none
module testbench;
    localparam int unsigned DEPTH = rol_pkg::LIST_DEPTH_DEF;
    localparam int unsigned LIMIT_CYCLES = 400000;

    typedef struct packed {
        logic [31:0] front_value;
        logic [1:0]  status;
        logic [4:0]  entry_count;
    } list_result_t;

    typedef struct {
        logic [1:0]  mode;
        logic [31:0] key;
        logic        has_fixed;   // expected result typed in
        list_result_t fixed;
    } op_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;

    // shadow copy of the list
    logic [31:0] shadow_list[DEPTH];
    int unsigned shadow_fill;
    list_result_t pending_results[$];
    op_row_t     row_table[$];
    int          errors = 0;
    longint      cycles = 0;
    bit          hold_off = 1'b0;      // long receiver stall request

    recency_ordered_list_core dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("FAIL recency_ordered_list_core");
            $finish;
        end
    end

    // apply one operation to the shadow list and return its result
    function automatic list_result_t apply_list_op(logic [1:0] mode, logic [31:0] key);
        list_result_t r;
        int unsigned pos;
        r = '0;
        r.status = rol_pkg::ST_OK;
        pos = shadow_fill;
        if (mode == rol_pkg::MODE_APPEND)
        begin
            if (shadow_fill >= DEPTH)
                r.status = rol_pkg::ST_FULL;
            else
            begin
                shadow_list[shadow_fill] = key;
                shadow_fill++;
            end
        end
        else if (mode == rol_pkg::MODE_POP)
        begin
            if (shadow_fill == 0)
                r.status = rol_pkg::ST_EMPTY;
            else
            begin
                r.front_value = shadow_list[0];
                for (int i = 0; i + 1 < shadow_fill; i++)
                    shadow_list[i] = shadow_list[i + 1];
                shadow_fill--;
            end
        end
        else
        begin
            for (int i = shadow_fill - 1; i >= 0; i--)
                if (shadow_list[i] == key)
                    pos = i;
            if (pos >= shadow_fill)
                r.status = rol_pkg::ST_MISSING;
            else
            begin
                for (int i = pos; i + 1 < shadow_fill; i++)
                    shadow_list[i] = shadow_list[i + 1];
                if (mode == rol_pkg::MODE_MOVE)
                    shadow_list[shadow_fill - 1] = key;
                else
                    shadow_fill--;
            end
        end
        r.entry_count = shadow_fill[4:0];
        return r;
    endfunction

    // send one transaction after a random gap, predict on acceptance
    task automatic send_op(logic [1:0] mode, logic [31:0] key, bit has_fixed,
                           list_result_t fixed);
        int gap;
        list_result_t r;
        gap = $urandom_range(0, 10);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {6'b0, key, mode};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        r = apply_list_op(mode, key);
        if (has_fixed && r != fixed)
        begin
            $display("%0t table row disagrees: expected %h predicted %h", $time, fixed, r);
            errors++;
        end
        pending_results.push_back(has_fixed ? fixed : r);
    endtask

    function automatic list_result_t mk(logic [31:0] f, logic [1:0] s, logic [4:0] c);
        list_result_t r;
        r.front_value = f;
        r.status = s;
        r.entry_count = c;
        return r;
    endfunction

    function automatic void add_row(logic [1:0] mode, logic [31:0] key, bit has_fixed,
                                    list_result_t fixed);
        op_row_t row;
        row.mode = mode;
        row.key = key;
        row.has_fixed = has_fixed;
        row.fixed = fixed;
        row_table.push_back(row);
    endfunction

    // pick a key: mostly one already held so searches hit
    function automatic logic [31:0] pick_key();
        if (shadow_fill > 0 && $urandom_range(0, 3) != 0)
            return shadow_list[$urandom_range(0, shadow_fill - 1)];
        if ($urandom_range(0, 1) == 0)
            return $urandom_range(0, 7);
        return $urandom;
    endfunction

    // receiver: random stalls, plus one long hold-off
    initial
    begin
        int wait_cycles;
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                m_tready <= 1'b0;
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
            wait_cycles = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 10);
            if (wait_cycles > 0)
            begin
                m_tready <= 1'b0;
                repeat (wait_cycles - 1) @(posedge clk);
                @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
        end
    end

    // compare each result transaction with the oldest expectation
    always @(posedge clk)
    begin
        list_result_t got, want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tdata[31:0], m_tdata[33:32], m_tdata[38:34]};
            if (pending_results.size() == 0)
            begin
                $display("%0t unexpected result: expected none actual %h", $time, got);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.front_value !== want.front_value)
                begin
                    $display("%0t front_value: expected %h actual %h", $time,
                             want.front_value, got.front_value);
                    errors++;
                end
                if (got.status !== want.status)
                begin
                    $display("%0t status: expected %0d actual %0d", $time,
                             want.status, got.status);
                    errors++;
                end
                if (got.entry_count !== want.entry_count)
                begin
                    $display("%0t entry_count: expected %0d actual %0d", $time,
                             want.entry_count, got.entry_count);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        int mode_pick;
        logic [1:0] mode;
        for (int i = 0; i < DEPTH; i++)
            shadow_list[i] = '0;
        shadow_fill = 0;

        // directed table: empty cases, extremes, full list, tail move, duplicates
        add_row(rol_pkg::MODE_POP, 32'h0, 1, mk(32'h0, rol_pkg::ST_EMPTY, 5'd0));
        add_row(rol_pkg::MODE_MOVE, 32'h5, 1, mk(32'h0, rol_pkg::ST_MISSING, 5'd0));
        add_row(rol_pkg::MODE_REMOVE, 32'h5, 1, mk(32'h0, rol_pkg::ST_MISSING, 5'd0));
        add_row(rol_pkg::MODE_APPEND, 32'h8000_0000, 1, mk(32'h0, rol_pkg::ST_OK, 5'd1));
        add_row(rol_pkg::MODE_APPEND, 32'h7FFF_FFFF, 1, mk(32'h0, rol_pkg::ST_OK, 5'd2));
        add_row(rol_pkg::MODE_APPEND, 32'hFFFF_FFFF, 1, mk(32'h0, rol_pkg::ST_OK, 5'd3));
        add_row(rol_pkg::MODE_MOVE, 32'hFFFF_FFFF, 1, mk(32'h0, rol_pkg::ST_OK, 5'd3));
        add_row(rol_pkg::MODE_MOVE, 32'h8000_0000, 0, '0);
        add_row(rol_pkg::MODE_POP, 32'hFFFF_FFFF, 1,
                mk(32'h7FFF_FFFF, rol_pkg::ST_OK, 5'd2));
        for (int i = 0; i < 14; i++)
            add_row(rol_pkg::MODE_APPEND, i % 3, 0, '0);
        add_row(rol_pkg::MODE_APPEND, 32'h0, 1, mk(32'h0, rol_pkg::ST_FULL, 5'd16));
        add_row(rol_pkg::MODE_REMOVE, 32'h1, 0, '0);
        add_row(rol_pkg::MODE_MOVE, 32'h0, 0, '0);
        add_row(rol_pkg::MODE_MOVE, 32'h1234_5678, 1,
                mk(32'h0, rol_pkg::ST_MISSING, 5'd15));
        add_row(rol_pkg::MODE_POP, 32'h0, 0, '0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (row_table[i])
            send_op(row_table[i].mode, row_table[i].key, row_table[i].has_fixed,
                    row_table[i].fixed);

        // random traffic; fill level wanders so full and empty are both reached
        for (int n = 0; n < 400; n++)
        begin
            if (n == 100)
                hold_off = 1'b1;
            if (n == 250)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
                while (pending_results.size() != 0) @(posedge clk);
            end
            mode_pick = $urandom_range(0, 9);
            if (mode_pick < 4)
                mode = ((n / 60) % 2 == 0) ? rol_pkg::MODE_APPEND : rol_pkg::MODE_POP;
            else
                mode = 2'($urandom_range(0, 3));
            send_op(mode, pick_key(), 0, '0);
        end
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("PASS recency_ordered_list_core");
        else
            $display("FAIL recency_ordered_list_core");
        $finish;
    end
endmodule
`default_nettype wire
